@@ sv/mpm_pkg.sv @@
// Package for the modular matrix power block: field widths, codes, the prime
// and its Barrett constant, and the small modular helper functions.
// No dependencies.
package mpm_pkg;

	// Field widths of the command and result words
	localparam int unsigned POS_W  = 3;
	localparam int unsigned VAL_W  = 30;
	localparam int unsigned EXP_W  = 63;
	localparam int unsigned DIM_W  = 4;

	// Datapath widths of the modular multiplier
	localparam int unsigned PROD_W = 60;   // full product of two residues
	localparam int unsigned Q1_LSB = 29;   // Barrett: x >> (k-1), k = 30
	localparam int unsigned Q2_W   = 62;   // q1 * m
	localparam int unsigned Q3_LSB = 31;   // Barrett: >> (k+1)
	localparam int unsigned RED_W  = 32;   // remainder before correction, < 3p

	// Command codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_RUN  = 1'b1;

	// Reset value of the dimension register
	localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

	// Modulus and Barrett reciprocal floor(2^60 / p)
	localparam logic [VAL_W-1:0] PRIME     = 30'd1000000007;
	localparam logic [30:0]      BARRETT_M = 31'd1152921496;
	localparam logic [RED_W-1:0] PRIME_R   = 32'd1000000007;
	localparam logic [RED_W-1:0] PRIME_2R  = 32'd2000000014;

	// (a + b) mod p for a, b < p
	function automatic logic [VAL_W-1:0] mod_add(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b);
		logic [VAL_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, PRIME}) begin
			s = s - {1'b0, PRIME};
		end
		return s[VAL_W-1:0];
	endfunction

	// x mod p for x < 3p
	function automatic logic [VAL_W-1:0] mod_red3(input logic [RED_W-1:0] x);
		logic [RED_W-1:0] r;
		if (x >= PRIME_2R) begin
			r = x - PRIME_2R;
		end else if (x >= PRIME_R) begin
			r = x - PRIME_R;
		end else begin
			r = x;
		end
		return r[VAL_W-1:0];
	endfunction

	// x mod p for any 30-bit x (always below 2p)
	function automatic logic [VAL_W-1:0] mod_fold(input logic [VAL_W-1:0] x);
		logic [VAL_W-1:0] r;
		if (x >= PRIME) begin
			r = x - PRIME;
		end else begin
			r = x;
		end
		return r;
	endfunction

endpackage

@@ sv/mpm_cmd_if.sv @@
// Command channel of the modular matrix power block: valid/ready plus the
// load/run word. Depends on mpm_pkg.
interface mpm_cmd_if
	import mpm_pkg::*;
();
	logic             valid;
	logic             ready;
	logic             op;
	logic [POS_W-1:0] row;
	logic [POS_W-1:0] col;
	logic [VAL_W-1:0] elem_value;
	logic [EXP_W-1:0] exponent;

	modport source(output valid, output op, output row, output col,
		output elem_value, output exponent, input ready);
	modport sink(input valid, input op, input row, input col,
		input elem_value, input exponent, output ready);
endinterface

@@ sv/mpm_res_if.sv @@
// Result channel of the modular matrix power block: valid/ready plus one
// element word of the power. Depends on mpm_pkg.
interface mpm_res_if
	import mpm_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] out_row;
	logic [POS_W-1:0] out_col;
	logic [VAL_W-1:0] out_value;
	logic             last;

	modport source(output valid, output out_row, output out_col,
		output out_value, output last, input ready);
	modport sink(input valid, input out_row, input out_col,
		input out_value, input last, output ready);
endinterface

@@ sv/mpm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mpm_ram #(
	parameter int unsigned WIDTH = 30,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ sv/matrix_power_mod_prime.sv @@
// Modular matrix power (mod 1000000007), square-and-multiply on one shared pipelined MAC.
// Load word: next word may follow at once. A run word, with L the exponent bit length, takes
// P = L + popcount(exponent) matrix products, each paced by the single MAC issue slot.
// One word at a time: cmd.ready is low from run acceptance until the last result is taken.
// arst_n clears control, sets matrix_dim to 8 and marks every base entry as zero.
module matrix_power_mod_prime
	import mpm_pkg::*;
#(
	parameter int unsigned MAX_DIM = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [DIM_W-1:0] cfg_wdata,
	mpm_cmd_if.sink          cmd,
	mpm_res_if.source        res
);
	localparam int unsigned IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int unsigned ADDR_W = 2 * IDX_W;
	localparam int unsigned DEPTH  = 2 ** ADDR_W;

	typedef enum logic [8:0] {
		ST_IDLE      = 9'b000000001,
		ST_INIT      = 9'b000000010,
		ST_BIT       = 9'b000000100,
		ST_MUL       = 9'b000001000,
		ST_DRAIN     = 9'b000010000,
		ST_COPY      = 9'b000100000,
		ST_EMIT_RD   = 9'b001000000,
		ST_EMIT_LD   = 9'b010000000,
		ST_EMIT_WAIT = 9'b100000000
	} state_t;

	typedef struct packed {
		logic              v;
		logic              first;
		logic              last;
		logic [ADDR_W-1:0] addr;
	} tag_t;

	state_t            state_q;
	logic [DIM_W-1:0]  matrix_dim_q;
	logic [DIM_W-1:0]  dim_clamp;
	logic [IDX_W-1:0]  dim_m1_q;
	logic [IDX_W-1:0]  r_q, c_q, k_q;
	logic              r_end, c_end, k_end, rc_last;
	logic [EXP_W-1:0]  exp_q;
	logic              mode_acc_q;
	logic              acc_done_q;
	logic [DEPTH-1:0]  base_vld_q;
	logic              cmd_acc;
	logic              load_we;
	logic [ADDR_W-1:0] load_addr;
	logic [ADDR_W-1:0] rc_addr, rk_addr, kc_addr;

	// RAM ports
	logic              base_we;
	logic [ADDR_W-1:0] base_waddr;
	logic [VAL_W-1:0]  base_wdata;
	logic [VAL_W-1:0]  base_a_rd, base_b_rd;
	logic              acc_we;
	logic [ADDR_W-1:0] acc_waddr, acc_raddr;
	logic [VAL_W-1:0]  acc_wdata, acc_rd;
	logic [VAL_W-1:0]  scr_rd;

	// MAC pipeline
	tag_t              tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic              a_vld_s1, b_vld_s1;
	logic [VAL_W-1:0]  a_s1, b_s1;
	logic [PROD_W-1:0] prod_s2;
	logic [Q2_W-1:0]   q2_s3;
	logic [RED_W-1:0]  x_lo_s3, x_lo_s4;
	logic [RED_W-1:0]  qp_s4;
	logic [VAL_W-1:0]  red_s5;
	logic [VAL_W-1:0]  acc_q;
	logic              wr_s6;
	logic [ADDR_W-1:0] wr_addr_s6;
	logic              pipe_busy;

	// copy pass and output register
	logic              cp_v_s1;
	logic [ADDR_W-1:0] cp_addr_s1;
	logic              out_v_q;
	logic [POS_W-1:0]  out_row_q, out_col_q;
	logic [VAL_W-1:0]  out_value_q;
	logic              out_last_q;

	// handshake and addressing
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign load_we   = cmd_acc && (cmd.op == OP_LOAD)
		&& ({1'b0, cmd.row} < DIM_W'(MAX_DIM)) && ({1'b0, cmd.col} < DIM_W'(MAX_DIM));
	assign load_addr = {cmd.row[IDX_W-1:0], cmd.col[IDX_W-1:0]};
	assign rc_addr   = {r_q, c_q};
	assign rk_addr   = {r_q, k_q};
	assign kc_addr   = {k_q, c_q};
	assign r_end     = (r_q == dim_m1_q);
	assign c_end     = (c_q == dim_m1_q);
	assign k_end     = (k_q == dim_m1_q);
	assign rc_last   = r_end && c_end;

	// active side: zero acts as one, oversize acts as MAX_DIM
	always_comb begin
		if (matrix_dim_q == '0) begin
			dim_clamp = DIM_W'(1);
		end else if (matrix_dim_q > DIM_W'(MAX_DIM)) begin
			dim_clamp = DIM_W'(MAX_DIM);
		end else begin
			dim_clamp = matrix_dim_q;
		end
	end

	// base write port: load, copy of a square, final write-back on emission
	always_comb begin
		base_we    = 1'b0;
		base_waddr = load_addr;
		base_wdata = mod_fold(cmd.elem_value);
		if (load_we) begin
			base_we = 1'b1;
		end else if (cp_v_s1 && !mode_acc_q) begin
			base_we    = 1'b1;
			base_waddr = cp_addr_s1;
			base_wdata = scr_rd;
		end else if (state_q == ST_EMIT_LD) begin
			base_we    = 1'b1;
			base_waddr = rc_addr;
			base_wdata = acc_rd;
		end
	end

	// accumulator write port: identity fill or copy of an accumulate product
	always_comb begin
		acc_we    = 1'b0;
		acc_waddr = rc_addr;
		acc_wdata = (r_q == c_q) ? VAL_W'(1) : '0;
		if (state_q == ST_INIT) begin
			acc_we = 1'b1;
		end else if (cp_v_s1 && mode_acc_q) begin
			acc_we    = 1'b1;
			acc_waddr = cp_addr_s1;
			acc_wdata = scr_rd;
		end
	end

	assign acc_raddr = (state_q == ST_MUL) ? rk_addr : rc_addr;

	// base held twice so left and right operands read in the same cycle
	mpm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_base_a (
		.clk(clk), .we(base_we), .waddr(base_waddr), .wdata(base_wdata),
		.raddr(rk_addr), .rdata(base_a_rd)
	);

	mpm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_base_b (
		.clk(clk), .we(base_we), .waddr(base_waddr), .wdata(base_wdata),
		.raddr(kc_addr), .rdata(base_b_rd)
	);

	mpm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_accum (
		.clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
		.raddr(acc_raddr), .rdata(acc_rd)
	);

	mpm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_scratch (
		.clk(clk), .we(wr_s6), .waddr(wr_addr_s6), .wdata(acc_q),
		.raddr(rc_addr), .rdata(scr_rd)
	);

	// operand select; never-written base entries read as zero
	assign a_s1 = mode_acc_q ? acc_rd : (a_vld_s1 ? base_a_rd : '0);
	assign b_s1 = b_vld_s1 ? base_b_rd : '0;

	assign pipe_busy = tag_s1.v || tag_s2.v || tag_s3.v || tag_s4.v || tag_s5.v || wr_s6;

	// sequencer, counters and pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			matrix_dim_q <= DIM_RESET;
			r_q          <= '0;
			c_q          <= '0;
			k_q          <= '0;
			mode_acc_q   <= 1'b0;
			acc_done_q   <= 1'b0;
			base_vld_q   <= '0;
			tag_s1       <= '0;
			tag_s2       <= '0;
			tag_s3       <= '0;
			tag_s4       <= '0;
			tag_s5       <= '0;
			wr_s6        <= 1'b0;
			cp_v_s1      <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				matrix_dim_q <= cfg_wdata;
			end
			if (base_we) begin
				base_vld_q[base_waddr] <= 1'b1;
			end

			tag_s1 <= '{v: (state_q == ST_MUL), first: (k_q == '0), last: k_end,
				addr: rc_addr};
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			wr_s6  <= tag_s5.v && tag_s5.last;
			cp_v_s1 <= (state_q == ST_COPY);

			case (state_q)
				ST_IDLE: begin
					if (cmd_acc && (cmd.op == OP_RUN)) begin
						state_q <= ST_INIT;
						r_q     <= '0;
						c_q     <= '0;
					end
				end
				ST_INIT: begin
					acc_done_q <= 1'b0;
					if (rc_last) begin
						state_q <= ST_BIT;
						r_q     <= '0;
						c_q     <= '0;
					end else if (c_end) begin
						c_q <= '0;
						r_q <= r_q + 1'b1;
					end else begin
						c_q <= c_q + 1'b1;
					end
				end
				ST_BIT: begin
					r_q <= '0;
					c_q <= '0;
					k_q <= '0;
					if (exp_q == '0) begin
						state_q <= ST_EMIT_RD;
					end else begin
						mode_acc_q <= exp_q[0] && !acc_done_q;
						state_q    <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (k_end) begin
						k_q <= '0;
						if (rc_last) begin
							state_q <= ST_DRAIN;
							r_q     <= '0;
							c_q     <= '0;
						end else if (c_end) begin
							c_q <= '0;
							r_q <= r_q + 1'b1;
						end else begin
							c_q <= c_q + 1'b1;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						state_q <= ST_COPY;
					end
				end
				ST_COPY: begin
					if (rc_last) begin
						state_q    <= ST_BIT;
						acc_done_q <= mode_acc_q;
						r_q        <= '0;
						c_q        <= '0;
					end else if (c_end) begin
						c_q <= '0;
						r_q <= r_q + 1'b1;
					end else begin
						c_q <= c_q + 1'b1;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					out_v_q <= 1'b1;
					state_q <= ST_EMIT_WAIT;
				end
				ST_EMIT_WAIT: begin
					if (res.ready) begin
						out_v_q <= 1'b0;
						if (rc_last) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_EMIT_RD;
							if (c_end) begin
								c_q <= '0;
								r_q <= r_q + 1'b1;
							end else begin
								c_q <= c_q + 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath: run set-up, exponent shifter, modular MAC, output word
	always_ff @(posedge clk) begin
		if (cmd_acc && (cmd.op == OP_RUN)) begin
			exp_q    <= cmd.exponent;
			dim_m1_q <= IDX_W'(dim_clamp - DIM_W'(1));
		end else if ((state_q == ST_COPY) && rc_last && !mode_acc_q) begin
			exp_q <= exp_q >> 1;
		end

		a_vld_s1 <= base_vld_q[rk_addr];
		b_vld_s1 <= base_vld_q[kc_addr];

		// product, then Barrett reduction over three stages
		prod_s2 <= PROD_W'(a_s1) * PROD_W'(b_s1);
		q2_s3   <= Q2_W'(prod_s2[PROD_W-1:Q1_LSB]) * Q2_W'(BARRETT_M);
		x_lo_s3 <= prod_s2[RED_W-1:0];
		qp_s4   <= RED_W'(q2_s3[Q2_W-1:Q3_LSB]) * RED_W'(PRIME);
		x_lo_s4 <= x_lo_s3;
		red_s5  <= mod_red3(x_lo_s4 - qp_s4);

		// running sum for one element, restarted on its first term
		if (tag_s5.v) begin
			acc_q <= mod_add(tag_s5.first ? '0 : acc_q, red_s5);
		end
		wr_addr_s6 <= tag_s5.addr;
		cp_addr_s1 <= rc_addr;

		if (state_q == ST_EMIT_LD) begin
			out_row_q   <= POS_W'(r_q);
			out_col_q   <= POS_W'(c_q);
			out_value_q <= acc_rd;
			out_last_q  <= rc_last;
		end
	end

	assign res.valid     = out_v_q;
	assign res.out_row   = out_row_q;
	assign res.out_col   = out_col_q;
	assign res.out_value = out_value_q;
	assign res.last      = out_last_q;

	// a result word is only shown while the emitter waits for it
	a_out_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (state_q == ST_EMIT_WAIT))
		else $error("result valid outside emission");

	// scratch is read back only once every product term has landed
	a_copy_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY) |-> !pipe_busy)
		else $error("copy pass started with MAC pipeline busy");

	// values leaving the MAC are fully reduced
	a_red_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s5.v |-> (red_s5 < PRIME))
		else $error("Barrett remainder not reduced");

	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		wr_s6 |-> (acc_q < PRIME))
		else $error("element sum not reduced");

	// the final word hands control back to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.ready && res.last) |=> (state_q == ST_IDLE))
		else $error("no return to idle after final word");

endmodule

@@ tb/tb_matrix_power_mod_prime.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for matrix_power_mod_prime: drives load and run words, predicts
// every element of each power mod 1000000007 and checks the result words in order.
// Depends on mpm_pkg, mpm_cmd_if, mpm_res_if and the block itself.

import mpm_pkg::*;

localparam int unsigned MAX_SIDE = 8;

typedef struct packed {
	bit             op;
	bit [POS_W-1:0] row;
	bit [POS_W-1:0] col;
	bit [VAL_W-1:0] val;
	bit [EXP_W-1:0] expo;
} cmd_word_t;

typedef struct packed {
	logic [POS_W-1:0] row;
	logic [POS_W-1:0] col;
	logic [VAL_W-1:0] val;
	logic             last;
} elem_word_t;

// Shadow of the stored matrices plus the queue of element words still owed
class matpow_board;
	bit [DIM_W-1:0] dim_reg;
	bit [VAL_W-1:0] base_m  [MAX_SIDE][MAX_SIDE];
	bit [VAL_W-1:0] accum_m [MAX_SIDE][MAX_SIDE];
	elem_word_t     pending_elems[$];
	int unsigned    errors;

	function void clear();
		dim_reg = DIM_RESET;
		for (int r = 0; r < MAX_SIDE; r++) begin
			for (int c = 0; c < MAX_SIDE; c++) begin
				base_m[r][c]  = '0;
				accum_m[r][c] = '0;
			end
		end
		pending_elems.delete();
		errors = 0;
	endfunction

	function void set_dim(input bit [DIM_W-1:0] v);
		dim_reg = v;
	endfunction

	// zero acts as one, anything past the storage as the full side
	function int unsigned active_side();
		if (dim_reg == 0) return 1;
		if (dim_reg > MAX_SIDE) return MAX_SIDE;
		return dim_reg;
	endfunction

	function int unsigned pending();
		return pending_elems.size();
	endfunction

	// square: base = base * base, else accum = accum * base; active part only
	function void mul_step(input bit square);
		bit [VAL_W-1:0]  prod [MAX_SIDE][MAX_SIDE];
		longint unsigned acc;
		longint unsigned lhs;
		int unsigned     d;
		d = active_side();
		for (int r = 0; r < d; r++) begin
			for (int c = 0; c < d; c++) begin
				acc = 0;
				for (int k = 0; k < d; k++) begin
					lhs = square ? base_m[r][k] : accum_m[r][k];
					acc = (acc + lhs * base_m[k][c]) % PRIME;
				end
				prod[r][c] = acc[VAL_W-1:0];
			end
		end
		for (int r = 0; r < d; r++) begin
			for (int c = 0; c < d; c++) begin
				if (square) base_m[r][c] = prod[r][c];
				else accum_m[r][c] = prod[r][c];
			end
		end
	endfunction

	// Accepted command word: store an element, or raise the power and queue its words
	function void note_word(input cmd_word_t w);
		elem_word_t     e;
		bit [EXP_W-1:0] expo;
		int unsigned    d;
		if (w.op == OP_LOAD) begin
			// row and col are 3 bits, so every load lands in storage
			base_m[w.row][w.col] = w.val % PRIME;
			return;
		end
		d = active_side();
		for (int r = 0; r < d; r++) begin
			for (int c = 0; c < d; c++) begin
				accum_m[r][c] = (r == c) ? VAL_W'(1) : '0;
			end
		end
		// square-and-multiply, low exponent bit first
		expo = w.expo;
		while (expo != 0) begin
			if (expo[0]) mul_step(1'b0);
			mul_step(1'b1);
			expo = expo >> 1;
		end
		for (int r = 0; r < d; r++) begin
			for (int c = 0; c < d; c++) begin
				base_m[r][c] = accum_m[r][c];
				e.row  = POS_W'(r);
				e.col  = POS_W'(c);
				e.val  = accum_m[r][c];
				e.last = (r == d - 1) && (c == d - 1);
				pending_elems.push_back(e);
			end
		end
	endfunction

	function void compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// Accepted result word against the oldest owed element
	function void check_elem(input elem_word_t got);
		elem_word_t want;
		if (pending_elems.size() == 0) begin
			$error("result word with nothing owed: row %0d col %0d value %0d last %0b",
				got.row, got.col, got.val, got.last);
			errors++;
			return;
		end
		want = pending_elems.pop_front();
		compare_field("out_row", 64'(want.row), 64'(got.row));
		compare_field("out_col", 64'(want.col), 64'(got.col));
		compare_field("out_value", 64'(want.val), 64'(got.val));
		compare_field("last", 64'(want.last), 64'(got.last));
	endfunction
endclass

module tb_matrix_power_mod_prime;

	localparam int unsigned HALF_PERIOD      = 5;
	localparam int unsigned RESET_CYCLES     = 11;
	localparam int unsigned CFG_SETTLE       = 16;
	localparam int unsigned END_SETTLE       = 100;
	localparam int unsigned HOLD_CYCLES      = 4000;
	localparam int unsigned RANDOM_PER_PHASE = 20;
	// several times the worst case, which is reached only if every word were a long run
	localparam longint unsigned TIMEOUT_NS   = 64'd60_000_000;

	typedef enum int unsigned {
		PH_STEADY,
		PH_SEND_IDLE,
		PH_RECV_STALL,
		PH_BOTH,
		PH_PRESSURE,
		PH_COUNT
	} phase_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [DIM_W-1:0] cfg_wdata;

	mpm_cmd_if cmd_bus();
	mpm_res_if res_bus();

	matrix_power_mod_prime #(
		.MAX_DIM(MAX_SIDE)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd_bus),
		.res      (res_bus)
	);

	matpow_board board;

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned hold_asked = 0;
	int unsigned hold_done  = 0;
	int unsigned hold_left  = 0;

	// Clock
	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	// Sample register writes and both handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) board.set_dim(cfg_wdata);
			if (cmd_bus.valid && cmd_bus.ready) begin
				board.note_word({cmd_bus.op, cmd_bus.row, cmd_bus.col,
					cmd_bus.elem_value, cmd_bus.exponent});
			end
			if (res_bus.valid && res_bus.ready) begin
				board.check_elem({res_bus.out_row, res_bus.out_col,
					res_bus.out_value, res_bus.last});
			end
		end
	end

	// Result receiver: random stalls, or a long hold-off when one is asked for
	always @(negedge clk) begin
		if (hold_left != 0) begin
			res_bus.ready <= 1'b0;
			hold_left     <= hold_left - 1;
		end else if (hold_asked != hold_done) begin
			res_bus.ready <= 1'b0;
			hold_done     <= hold_done + 1;
			hold_left     <= HOLD_CYCLES;
		end else begin
			res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Offer one command word, with random idle cycles in front; returns at a falling edge
	task automatic send_word(input cmd_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_bus.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_bus.valid      <= 1'b1;
		cmd_bus.op         <= w.op;
		cmd_bus.row        <= w.row;
		cmd_bus.col        <= w.col;
		cmd_bus.elem_value <= w.val;
		cmd_bus.exponent   <= w.expo;
		@(posedge clk);
		while (!cmd_bus.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_load(input int unsigned r, input int unsigned c,
			input bit [VAL_W-1:0] v);
		cmd_word_t w;
		w      = '0;
		w.op   = OP_LOAD;
		w.row  = POS_W'(r);
		w.col  = POS_W'(c);
		w.val  = v;
		send_word(w);
	endtask

	task automatic send_run(input bit [EXP_W-1:0] e);
		cmd_word_t w;
		w      = '0;
		w.op   = OP_RUN;
		w.expo = e;
		send_word(w);
	endtask

	// Stop offering, wait for every owed word, then let the block go quiet
	task automatic settle(input int unsigned extra);
		cmd_bus.valid <= 1'b0;
		do @(negedge clk); while (board.pending() != 0);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_dim(input logic [DIM_W-1:0] v);
		settle(CFG_SETTLE);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Random word; unused fields carry noise
	function automatic cmd_word_t random_word(input int unsigned side);
		cmd_word_t w;
		w.op   = ($urandom_range(3) == 0) ? OP_RUN : OP_LOAD;
		w.row  = POS_W'($urandom_range(MAX_SIDE - 1));
		w.col  = POS_W'($urandom_range(MAX_SIDE - 1));
		w.val  = VAL_W'($urandom);
		w.expo = EXP_W'({$urandom, $urandom});
		if (w.op == OP_LOAD) begin
			// mostly inside the active part so the runs see fresh content
			if ($urandom_range(7) != 0) begin
				w.row = POS_W'($urandom_range(side - 1));
				w.col = POS_W'($urandom_range(side - 1));
			end
			case ($urandom_range(9))
				0: w.val = VAL_W'($urandom_range(3));
				1: w.val = VAL_W'($urandom);
				default: w.val = VAL_W'($urandom_range(PRIME - 1));
			endcase
		end else if (side > 4 || $urandom_range(5) != 0) begin
			// full-length exponents only where the side keeps each product short
			if ($urandom_range(9) == 0) w.expo = '0;
			else w.expo = EXP_W'($urandom_range(side <= 4 ? 4095 : 255));
		end
		return w;
	endfunction

	// Directed words: corner values, dimension clamping, identity cases
	task automatic run_directed();
		// reset contents are zero, and power zero must still give the identity
		send_run('0);
		// unreduced values: all ones and the prime itself
		send_load(0, 0, '1);
		send_load(7, 7, PRIME);
		send_load(0, 7, PRIME - 1);
		send_load(7, 0, 30'd123456789);
		send_run(EXP_W'(1));
		send_run(EXP_W'(2));
		// side zero acts as one; the element at (3,3) sits outside and must survive
		write_dim(4'd0);
		send_load(0, 0, 30'd5);
		send_load(3, 3, 30'd9);
		send_run('1);
		// above the storage acts as the full side
		write_dim(4'd15);
		send_run(EXP_W'(3));
		// 2x2 Fibonacci step, with a load outside the active part
		write_dim(4'd2);
		send_load(0, 0, 30'd1);
		send_load(0, 1, 30'd1);
		send_load(1, 0, 30'd1);
		send_load(1, 1, 30'd0);
		send_load(5, 5, PRIME - 1);
		send_run(EXP_W'(10));
		send_run({1'b1, {(EXP_W - 1){1'b0}}});
		send_run('0);
	endtask

	task automatic run_random_phase(input phase_t ph);
		cmd_word_t        w;
		logic [DIM_W-1:0] dim_val;
		int unsigned      side;
		case ($urandom_range(9))
			0: dim_val = 4'd0;
			1: dim_val = 4'd15;
			2: dim_val = 4'd8;
			3: dim_val = DIM_W'($urandom_range(9, 15));
			default: dim_val = DIM_W'($urandom_range(1, 5));
		endcase
		write_dim(dim_val);
		side = board.active_side();
		case (ph)
			PH_SEND_IDLE: begin
				send_idle_pct  = 62;
				recv_stall_pct <= 0;
			end
			PH_RECV_STALL: begin
				send_idle_pct  = 0;
				recv_stall_pct <= 62;
			end
			PH_BOTH: begin
				send_idle_pct  = 9;
				recv_stall_pct <= 9;
			end
			default: begin
				send_idle_pct  = 0;
				recv_stall_pct <= 0;
			end
		endcase
		if (ph == PH_PRESSURE) hold_asked <= hold_asked + 1;
		for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
			w = random_word(side);
			// short run first, so its words back up behind the held receiver
			if (ph == PH_PRESSURE && i == 0) begin
				w.op   = OP_RUN;
				w.expo = EXP_W'($urandom_range(1, 3));
			end
			send_word(w);
			if (ph == PH_PRESSURE && i == RANDOM_PER_PHASE / 2) settle(0);
		end
	endtask

	// Main sequence
	initial begin
		board = new();
		board.clear();
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		cmd_bus.valid      = 1'b0;
		cmd_bus.op         = OP_LOAD;
		cmd_bus.row        = '0;
		cmd_bus.col        = '0;
		cmd_bus.elem_value = '0;
		cmd_bus.exponent   = '0;
		res_bus.ready      = 1'b0;
		send_idle_pct      = 0;
		recv_stall_pct     = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		run_directed();
		for (int p = 0; p < PH_COUNT; p++) begin
			run_random_phase(phase_t'(p));
		end
		settle(END_SETTLE);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("matrix_power_mod_prime regression: pass");
		end else begin
			$display("matrix_power_mod_prime regression: fail");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("matrix_power_mod_prime regression: fail");
		$finish;
	end

endmodule

@@ sim.f @@
sv/mpm_pkg.sv
sv/mpm_cmd_if.sv
sv/mpm_res_if.sv
sv/mpm_ram.sv
sv/matrix_power_mod_prime.sv
tb/tb_matrix_power_mod_prime.sv
